### design/hlcv_pkg.sv
// ---------------------------------------------------------------------------
// hlcv_pkg: shared types and constants for the homogeneous line clipper
// Lane record, result record, register indexes, status codes, plane order.
// ---------------------------------------------------------------------------
`default_nettype none

package hlcv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int T_BITS        = 30;   // clip parameter fraction bits
    localparam int CFG_W         = 13;
    localparam int IDX_W         = 2;
    localparam int N_PLANES      = 6;
    localparam int N_LANES       = 2;
    localparam int W_IDX         = 3;

    // plane order: z+, z-, x+, x-, y+, y-
    localparam int PLANE_AXIS [N_PLANES] = '{2, 2, 0, 0, 1, 1};
    localparam bit PLANE_PLUS [N_PLANES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    localparam logic [IDX_W-1:0] REG_VIEW_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOUND_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_BOUND_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] RST_VIEW_WIDTH   = 13'd800;
    localparam logic [CFG_W-1:0] RST_VIEW_HEIGHT  = 13'd600;
    localparam logic [CFG_W-1:0] RST_BOUND_WIDTH  = 13'd800;
    localparam logic [CFG_W-1:0] RST_BOUND_HEIGHT = 13'd600;

    localparam logic signed [63:0] NX_LIMIT = 64'sd1 << 40;

    typedef enum logic [1:0] {
        STATUS_DRAW    = 2'd0,
        STATUS_BEHIND  = 2'd1,
        STATUS_CLIPPED = 2'd2,
        STATUS_OFF     = 2'd3
    } status_t;

    // one endpoint being clipped (p) toward the original other endpoint (q)
    typedef struct packed {
        logic [3:0][31:0] p;
        logic [3:0][31:0] q;
        logic             ok;
        logic             behind;
    } lane_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] dz;
        logic        off;
        logic        ok;
        logic        behind;
    } map_res_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### design/hlcv_div.sv
// ---------------------------------------------------------------------------
// hlcv_div: pipelined restoring divider
// N quotients over a shared divisor, one quotient bit per stage; a sideband
// word travels with each transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module hlcv_div #(
    parameter int N      = 1,
    parameter int DEN_W  = 34,
    parameter int QUO_W  = 31,
    parameter int SIDE_W = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [N-1:0][DEN_W-1:0]       rem0,   // must be below den
    input  wire logic [N-1:0][QUO_W-1:0]       num,
    input  wire logic [DEN_W-1:0]              den,
    input  wire logic [SIDE_W-1:0]             side_in,
    output logic                               out_valid,
    output logic [N-1:0][QUO_W-1:0]            quo,
    output logic [SIDE_W-1:0]                  side_out
);

    logic                          valid_reg [QUO_W];
    logic [N-1:0][DEN_W-1:0]       rem_reg   [QUO_W];
    logic [N-1:0][QUO_W-1:0]       num_reg   [QUO_W];
    logic [N-1:0][QUO_W-1:0]       quo_reg   [QUO_W];
    logic [DEN_W-1:0]              den_reg   [QUO_W];
    logic [SIDE_W-1:0]             side_reg  [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic                    valid_prev;
        logic [N-1:0][DEN_W-1:0] rem_prev;
        logic [N-1:0][QUO_W-1:0] num_prev;
        logic [N-1:0][QUO_W-1:0] quo_prev;
        logic [DEN_W-1:0]        den_prev;
        logic [SIDE_W-1:0]       side_prev;
        logic [N-1:0][DEN_W-1:0] rem_next;
        logic [N-1:0][QUO_W-1:0] num_next;
        logic [N-1:0][QUO_W-1:0] quo_next;
        logic [N-1:0][DEN_W:0]   trial;
        logic [N-1:0]            ge;

        if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = rem0;
            assign num_prev   = num;
            assign quo_prev   = '0;
            assign den_prev   = den;
            assign side_prev  = side_in;
        end else begin : g_next
            assign valid_prev = valid_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign num_prev   = num_reg[s-1];
            assign quo_prev   = quo_reg[s-1];
            assign den_prev   = den_reg[s-1];
            assign side_prev  = side_reg[s-1];
        end

        always_comb
        begin
            for (int i = 0; i < N; i++)
            begin
                trial[i]    = {rem_prev[i], num_prev[i][QUO_W-1]};
                ge[i]       = trial[i] >= {1'b0, den_prev};
                rem_next[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, den_prev})
                                    : trial[i][DEN_W-1:0];
                num_next[i] = {num_prev[i][QUO_W-2:0], 1'b0};
                quo_next[i] = {quo_prev[i][QUO_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                num_reg[s]  <= num_next;
                quo_reg[s]  <= quo_next;
                den_reg[s]  <= den_prev;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

### design/hlcv_plane.sv
// ---------------------------------------------------------------------------
// hlcv_plane: one clip plane for one lane
// Plane test and t = n/d setup, divider, split multiply, interpolate.
// ---------------------------------------------------------------------------
`default_nettype none

module hlcv_plane #(
    parameter int AXIS = 0,
    parameter bit PLUS = 1'b1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire hlcv_pkg::lane_t lane_in,
    output logic                out_valid,
    output hlcv_pkg::lane_t     lane_out
);

    localparam int T_BITS  = hlcv_pkg::T_BITS;
    localparam int DEN_W   = 34;
    localparam int QUO_W   = T_BITS + 1;
    localparam int NUMER_W = 33 + T_BITS;
    localparam int SIDE_W  = $bits(hlcv_pkg::lane_t) + 1;
    localparam int LO_W    = 17;
    localparam int HP_W    = 33 - LO_W + QUO_W;
    localparam int LP_W    = LO_W + QUO_W;
    localparam int R_W     = 64 - T_BITS;

    // setup
    logic signed [32:0]   pa, pw, qa, qw, aw, n, m;
    logic signed [33:0]   d;
    logic [32:0]          an;
    logic [33:0]          ad;
    logic                 act, kill, go;
    logic [NUMER_W-1:0]   numer;
    logic [DEN_W-1:0]     den;
    hlcv_pkg::lane_t      lane_set;

    always_comb
    begin
        pa = {lane_in.p[AXIS][31], lane_in.p[AXIS]};
        pw = {lane_in.p[hlcv_pkg::W_IDX][31], lane_in.p[hlcv_pkg::W_IDX]};
        qa = {lane_in.q[AXIS][31], lane_in.q[AXIS]};
        qw = {lane_in.q[hlcv_pkg::W_IDX][31], lane_in.q[hlcv_pkg::W_IDX]};
        aw = pw[32] ? -pw : pw;
        if (PLUS)
        begin
            act = pa > aw;
            n   = pw - pa;
            m   = qw - qa;
        end
        else
        begin
            act = pa < -aw;
            n   = pw + pa;
            m   = qw + qa;
        end
        d     = {n[32], n} - {m[32], m};
        an    = n[32] ? 33'(-n) : 33'(n);
        ad    = d[33] ? 34'(-d) : 34'(d);
        kill  = act && ((d == '0) || ({1'b0, an} > ad));
        go    = act && !kill;
        numer = go ? ({an, {T_BITS{1'b0}}} + NUMER_W'(ad >> 1)) : '0;
        den   = go ? ad : DEN_W'(1);
        lane_set    = lane_in;
        lane_set.ok = lane_in.ok & ~kill;
    end

    logic                 s0_valid_reg;
    hlcv_pkg::lane_t      s0_lane_reg;
    logic [NUMER_W-1:0]   s0_numer_reg;
    logic [DEN_W-1:0]     s0_den_reg;
    logic                 s0_tneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_lane_reg    <= lane_set;
            s0_numer_reg   <= numer;
            s0_den_reg     <= den;
            s0_tneg_reg    <= n[32] ^ d[33];
        end
    end

    // t magnitude, Q1.30
    logic                   dv_valid;
    logic [0:0][QUO_W-1:0]  dv_quo;
    logic [SIDE_W-1:0]      dv_side;
    logic [0:0][DEN_W-1:0]  dv_rem0;
    logic [0:0][QUO_W-1:0]  dv_num;
    hlcv_pkg::lane_t        dv_lane;
    logic                   dv_tneg;

    assign dv_rem0[0] = DEN_W'(s0_numer_reg[NUMER_W-1:QUO_W]);
    assign dv_num[0]  = s0_numer_reg[QUO_W-1:0];

    hlcv_div #(
        .N      (1),
        .DEN_W  (DEN_W),
        .QUO_W  (QUO_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .rem0      (dv_rem0),
        .num       (dv_num),
        .den       (s0_den_reg),
        .side_in   ({s0_tneg_reg, s0_lane_reg}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    assign dv_tneg = dv_side[SIDE_W-1];
    assign dv_lane = dv_side[SIDE_W-2:0];

    // partial products of |q - p| * t
    logic signed [32:0]  delta [4];
    logic [32:0]         dmag  [4];
    logic [HP_W-1:0]     hp_next [4];
    logic [LP_W-1:0]     lp_next [4];
    logic [3:0]          neg_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            delta[k]    = $signed({dv_lane.q[k][31], dv_lane.q[k]})
                        - $signed({dv_lane.p[k][31], dv_lane.p[k]});
            dmag[k]     = delta[k][32] ? 33'(-delta[k]) : 33'(delta[k]);
            neg_next[k] = delta[k][32] ^ dv_tneg;
            hp_next[k]  = HP_W'(dmag[k][32:LO_W]) * HP_W'(dv_quo[0]);
            lp_next[k]  = LP_W'(dmag[k][LO_W-1:0]) * LP_W'(dv_quo[0]);
        end
    end

    logic                s1_valid_reg;
    hlcv_pkg::lane_t     s1_lane_reg;
    logic [HP_W-1:0]     s1_hp_reg [4];
    logic [LP_W-1:0]     s1_lp_reg [4];
    logic [3:0]          s1_neg_reg;

    // sum and round to coordinate scale
    logic [63:0]         prod [4];
    logic [R_W-1:0]      r_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod[k]   = {s1_hp_reg[k], {LO_W{1'b0}}} + 64'(s1_lp_reg[k]);
            r_next[k] = R_W'((prod[k] + (64'd1 << (T_BITS - 1))) >> T_BITS);
        end
    end

    logic                s2_valid_reg;
    hlcv_pkg::lane_t     s2_lane_reg;
    logic [R_W-1:0]      s2_r_reg [4];
    logic [3:0]          s2_neg_reg;

    // move the endpoint
    logic signed [63:0]  step [4];
    logic signed [63:0]  moved [4];
    hlcv_pkg::lane_t     lane_next;

    always_comb
    begin
        lane_next = s2_lane_reg;
        for (int k = 0; k < 4; k++)
        begin
            step[k]  = $signed(64'(s2_r_reg[k]));
            moved[k] = 64'($signed(s2_lane_reg.p[k]))
                     + (s2_neg_reg[k] ? -step[k] : step[k]);
            lane_next.p[k] = hlcv_pkg::sat32(moved[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= dv_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid    <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_lane_reg <= dv_lane;
            s1_neg_reg  <= neg_next;
            s2_lane_reg <= s1_lane_reg;
            s2_neg_reg  <= s1_neg_reg;
            lane_out    <= lane_next;
            for (int k = 0; k < 4; k++)
            begin
                s1_hp_reg[k] <= hp_next[k];
                s1_lp_reg[k] <= lp_next[k];
                s2_r_reg[k]  <= r_next[k];
            end
        end
    end

endmodule

`default_nettype wire

### design/hlcv_map.sv
// ---------------------------------------------------------------------------
// hlcv_map: perspective divide, viewport mapping and screen check
// x, y, z over w on one shared-divisor divider, then scale and bound test.
// ---------------------------------------------------------------------------
`default_nettype none

module hlcv_map #(
    parameter int FRAC_BITS = hlcv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire hlcv_pkg::lane_t             lane_in,
    input  wire logic [hlcv_pkg::CFG_W-1:0]  view_width,
    input  wire logic [hlcv_pkg::CFG_W-1:0]  view_height,
    input  wire logic [hlcv_pkg::CFG_W-1:0]  bound_width,
    input  wire logic [hlcv_pkg::CFG_W-1:0]  bound_height,
    output logic                             out_valid,
    output hlcv_pkg::map_res_t               res
);

    localparam int NUM_W  = 32 + FRAC_BITS;
    localparam int A_W    = 42;
    localparam int P_W    = A_W + hlcv_pkg::CFG_W + 1;
    localparam int SIDE_W = 5;
    localparam logic signed [63:0] ONE    = 64'sd1 << FRAC_BITS;
    localparam logic signed [63:0] MARGIN = ((64'sd1 << FRAC_BITS) + 64'sd5) / 64'sd10;

    // numerators |p| * one + |w| / 2
    logic [31:0]                 wmag;
    logic [31:0]                 pmag [3];
    logic [2:0][NUM_W-1:0]       numer;
    logic [2:0]                  sgn;

    always_comb
    begin
        wmag = lane_in.p[hlcv_pkg::W_IDX][31] ? (32'd0 - lane_in.p[hlcv_pkg::W_IDX])
                                              : lane_in.p[hlcv_pkg::W_IDX];
        for (int k = 0; k < 3; k++)
        begin
            pmag[k]  = lane_in.p[k][31] ? (32'd0 - lane_in.p[k]) : lane_in.p[k];
            numer[k] = {pmag[k], {FRAC_BITS{1'b0}}} + NUM_W'(wmag >> 1);
            sgn[k]   = lane_in.p[k][31] ^ lane_in.p[hlcv_pkg::W_IDX][31];
        end
    end

    logic                    m0_valid_reg;
    logic [2:0][NUM_W-1:0]   m0_numer_reg;
    logic [31:0]             m0_den_reg;
    logic [SIDE_W-1:0]       m0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m0_valid_reg <= 1'b0;
        else if (en)
            m0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_numer_reg <= numer;
            m0_den_reg   <= wmag;
            m0_side_reg  <= {sgn,
                             lane_in.ok && (lane_in.p[hlcv_pkg::W_IDX] != '0),
                             lane_in.behind};
        end
    end

    logic                    dv_valid;
    logic [2:0][NUM_W-1:0]   dv_quo;
    logic [SIDE_W-1:0]       dv_side;

    hlcv_div #(
        .N      (3),
        .DEN_W  (32),
        .QUO_W  (NUM_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m0_valid_reg),
        .rem0      ('0),
        .num       (m0_numer_reg),
        .den       (m0_den_reg),
        .side_in   (m0_side_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    // signed quotients, clamp, offset by one
    logic signed [63:0] qs [3];
    logic signed [63:0] nx, ny;
    logic signed [63:0] ax, ay;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qs[k] = $signed(64'(dv_quo[k]));
            if (dv_side[2 + k])
                qs[k] = -qs[k];
        end
        nx = (qs[0] > hlcv_pkg::NX_LIMIT) ? hlcv_pkg::NX_LIMIT :
             (qs[0] < -hlcv_pkg::NX_LIMIT) ? -hlcv_pkg::NX_LIMIT : qs[0];
        ny = (qs[1] > hlcv_pkg::NX_LIMIT) ? hlcv_pkg::NX_LIMIT :
             (qs[1] < -hlcv_pkg::NX_LIMIT) ? -hlcv_pkg::NX_LIMIT : qs[1];
        ax = nx + ONE;
        ay = ONE - ny;
    end

    logic                 m1_valid_reg, m2_valid_reg, m3_valid_reg;
    logic signed [A_W-1:0] m1_ax_reg, m1_ay_reg;
    logic [31:0]          m1_dz_reg, m2_dz_reg, m3_dz_reg;
    logic [1:0]           m1_flag_reg, m2_flag_reg, m3_flag_reg;
    logic signed [P_W-1:0] m2_px_reg, m2_py_reg;
    logic [31:0]          m3_sx_reg, m3_sy_reg;

    // halve with rounding away from zero
    logic [P_W-1:0]       hx_mag, hy_mag;
    logic signed [63:0]   hx, hy;

    always_comb
    begin
        hx_mag = m2_px_reg[P_W-1] ? P_W'(-m2_px_reg) : P_W'(m2_px_reg);
        hy_mag = m2_py_reg[P_W-1] ? P_W'(-m2_py_reg) : P_W'(m2_py_reg);
        hx = $signed(64'((hx_mag + P_W'(1)) >> 1));
        hy = $signed(64'((hy_mag + P_W'(1)) >> 1));
        if (m2_px_reg[P_W-1])
            hx = -hx;
        if (m2_py_reg[P_W-1])
            hy = -hy;
    end

    // bound check
    logic signed [63:0]   sx_w, sy_w, bw, bh;
    logic                 off;

    always_comb
    begin
        sx_w = 64'($signed(m3_sx_reg));
        sy_w = 64'($signed(m3_sy_reg));
        bw   = $signed(64'(bound_width)) <<< FRAC_BITS;
        bh   = $signed(64'(bound_height)) <<< FRAC_BITS;
        off  = (sx_w < -MARGIN) || (sy_w < -MARGIN)
            || (sx_w > bw + MARGIN) || (sy_w > bh + MARGIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= dv_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            out_valid    <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_ax_reg   <= A_W'(ax);
            m1_ay_reg   <= A_W'(ay);
            m1_dz_reg   <= hlcv_pkg::sat32(qs[2]);
            m1_flag_reg <= dv_side[1:0];

            m2_px_reg   <= P_W'(m1_ax_reg) * $signed(P_W'({1'b0, view_width}));
            m2_py_reg   <= P_W'(m1_ay_reg) * $signed(P_W'({1'b0, view_height}));
            m2_dz_reg   <= m1_dz_reg;
            m2_flag_reg <= m1_flag_reg;

            m3_sx_reg   <= hlcv_pkg::sat32(hx);
            m3_sy_reg   <= hlcv_pkg::sat32(hy);
            m3_dz_reg   <= m2_dz_reg;
            m3_flag_reg <= m2_flag_reg;

            res         <= '{sx: m3_sx_reg, sy: m3_sy_reg, dz: m3_dz_reg, off: off,
                             ok: m3_flag_reg[1], behind: m3_flag_reg[0]};
        end
    end

endmodule

`default_nettype wire

### design/homogeneous_line_clip_viewport.sv
// ---------------------------------------------------------------------------
// homogeneous_line_clip_viewport: clip-space line clipper with viewport map
// Two lanes clip the endpoints against six planes, divide by w, map to the
// screen; a merge register forms the status and holds the result.
// ---------------------------------------------------------------------------
// One line segment (two clip-space endpoints, signed Q16.16) is taken per
// transaction and yields exactly one result transaction. A new segment can
// be accepted every cycle while in_stall is low. Each clip plane is a
// 31-stage t divider plus setup, multiply, round and update stages, and
// the map stage is a (32+FRAC_BITS)-stage divider for x/w, y/w, z/w plus
// scaling stages. The whole pipeline moves together; it halts only when
// its last stage holds a finished segment while the output register is
// full and stalled, so in_stall can rise only while out_valid is high and
// out_stall is asserted. Status 1 means both w were negative, 2 that an
// endpoint was clipped away (these return zero in all coordinate fields),
// 3 that an endpoint is more than 0.1 off screen (fields still valid), 0
// drawable. Configuration writes take effect at once and are to be made
// only when the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module homogeneous_line_clip_viewport #(
    parameter int FRAC_BITS = hlcv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_we,
    input  wire logic [hlcv_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [hlcv_pkg::CFG_W-1:0]  cfg_data,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [31:0]          start_x,
    input  wire logic signed [31:0]          start_y,
    input  wire logic signed [31:0]          start_z,
    input  wire logic signed [31:0]          start_w,
    input  wire logic signed [31:0]          end_x,
    input  wire logic signed [31:0]          end_y,
    input  wire logic signed [31:0]          end_z,
    input  wire logic signed [31:0]          end_w,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [31:0]               screen_x0,
    output logic signed [31:0]               screen_y0,
    output logic signed [31:0]               screen_x1,
    output logic signed [31:0]               screen_y1,
    output logic signed [31:0]               depth_z0,
    output logic signed [31:0]               depth_z1,
    output logic [1:0]                       status
);

    localparam int NL = hlcv_pkg::N_LANES;
    localparam int NP = hlcv_pkg::N_PLANES;

    // -----------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------
    logic [hlcv_pkg::CFG_W-1:0] view_width_reg, view_height_reg;
    logic [hlcv_pkg::CFG_W-1:0] bound_width_reg, bound_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg   <= hlcv_pkg::RST_VIEW_WIDTH;
            view_height_reg  <= hlcv_pkg::RST_VIEW_HEIGHT;
            bound_width_reg  <= hlcv_pkg::RST_BOUND_WIDTH;
            bound_height_reg <= hlcv_pkg::RST_BOUND_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hlcv_pkg::REG_VIEW_WIDTH:   view_width_reg   <= cfg_data;
                hlcv_pkg::REG_VIEW_HEIGHT:  view_height_reg  <= cfg_data;
                hlcv_pkg::REG_BOUND_WIDTH:  bound_width_reg  <= cfg_data;
                hlcv_pkg::REG_BOUND_HEIGHT: bound_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------
    // Pipeline advance: everything moves unless a finished segment at the
    // end of the pipe has nowhere to go.
    // -----------------------------------------------------------------
    logic                adv;
    logic                map_valid [NL];
    hlcv_pkg::map_res_t  map_res   [NL];
    logic                done;

    assign done     = map_valid[0] & map_valid[1];
    assign adv      = !(done && out_valid && out_stall);
    assign in_stall = !adv;

    // -----------------------------------------------------------------
    // Lanes: lane 0 clips the start point toward the end point, lane 1 the
    // reverse. Each lane is six plane stages in z+, z-, x+, x-, y+, y-
    // order, then the divide/map stage.
    // -----------------------------------------------------------------
    hlcv_pkg::lane_t  chain_lane  [NL][NP+1];
    logic             chain_valid [NL][NP+1];
    logic             behind;
    logic [3:0][31:0] pt_a, pt_b;

    assign pt_a   = {start_w, start_z, start_y, start_x};
    assign pt_b   = {end_w, end_z, end_y, end_x};
    assign behind = start_w[31] & end_w[31];

    assign chain_lane[0][0]  = '{p: pt_a, q: pt_b, ok: 1'b1, behind: behind};
    assign chain_lane[1][0]  = '{p: pt_b, q: pt_a, ok: 1'b1, behind: behind};
    assign chain_valid[0][0] = in_valid;
    assign chain_valid[1][0] = in_valid;

    for (genvar l = 0; l < NL; l++) begin : g_lane
        for (genvar j = 0; j < NP; j++) begin : g_plane
            hlcv_plane #(
                .AXIS (hlcv_pkg::PLANE_AXIS[j]),
                .PLUS (hlcv_pkg::PLANE_PLUS[j])
            ) u_plane (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (chain_valid[l][j]),
                .lane_in   (chain_lane[l][j]),
                .out_valid (chain_valid[l][j+1]),
                .lane_out  (chain_lane[l][j+1])
            );
        end

        hlcv_map #(
            .FRAC_BITS (FRAC_BITS)
        ) u_map (
            .clk          (clk),
            .rst_n        (rst_n),
            .en           (adv),
            .in_valid     (chain_valid[l][NP]),
            .lane_in      (chain_lane[l][NP]),
            .view_width   (view_width_reg),
            .view_height  (view_height_reg),
            .bound_width  (bound_width_reg),
            .bound_height (bound_height_reg),
            .out_valid    (map_valid[l]),
            .res          (map_res[l])
        );
    end

    // -----------------------------------------------------------------
    // Merge: status priority is behind, then clipped away, then off screen.
    // -----------------------------------------------------------------
    logic                 out_valid_reg, out_valid_next;
    hlcv_pkg::status_t    status_reg, status_next;
    logic [5:0][31:0]     field_reg, field_next;

    always_comb
    begin
        field_next = {map_res[1].dz, map_res[0].dz,
                      map_res[1].sy, map_res[1].sx,
                      map_res[0].sy, map_res[0].sx};
        priority if (map_res[0].behind)
        begin
            status_next = hlcv_pkg::STATUS_BEHIND;
            field_next  = '0;
        end
        else if (!(map_res[0].ok && map_res[1].ok))
        begin
            status_next = hlcv_pkg::STATUS_CLIPPED;
            field_next  = '0;
        end
        else if (map_res[0].off || map_res[1].off)
            status_next = hlcv_pkg::STATUS_OFF;
        else
            status_next = hlcv_pkg::STATUS_DRAW;

        if (adv && done)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && done)
        begin
            status_reg <= status_next;
            field_reg  <= field_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x0 = field_reg[0];
    assign screen_y0 = field_reg[1];
    assign screen_x1 = field_reg[2];
    assign screen_y1 = field_reg[3];
    assign depth_z0  = field_reg[4];
    assign depth_z1  = field_reg[5];
    assign status    = status_reg;

`ifndef NO_ASSERTIONS
    // rejected segments carry zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg == hlcv_pkg::STATUS_BEHIND
                   || status_reg == hlcv_pkg::STATUS_CLIPPED)
        |-> (field_reg == '0))
        else $error("rejected segment with nonzero fields");

    // input side only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && done))
        else $error("input stalled without a blocked result");

    // both lanes run in lockstep
    a_lane_lock: assert property (@(posedge clk) disable iff (!rst_n)
        map_valid[0] == map_valid[1])
        else $error("lane valid mismatch");

    // a register write lands
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == hlcv_pkg::REG_VIEW_WIDTH
        |=> view_width_reg == $past(cfg_data))
        else $error("view width write lost");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: line clipper with perspective divide and viewport mapping
// Drives segments through the valid/stall input, predicts each result with
// a fixed-point clip/divide/map model and compares every output transaction.
// ---------------------------------------------------------------------------
module testbench;

    typedef longint vec4_t [4];

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [31:0] sw;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic signed [31:0] ew;
    } segment_t;

    typedef struct {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] z0;
        logic signed [31:0] z1;
        hlcv_pkg::status_t  st;
    } screen_line_t;

    localparam int FRAC = hlcv_pkg::FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [hlcv_pkg::IDX_W-1:0] cfg_index = '0;
    logic [hlcv_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] start_x = '0, start_y = '0, start_z = '0, start_w = '0;
    logic signed [31:0] end_x = '0, end_y = '0, end_z = '0, end_w = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] screen_x0, screen_y0, screen_x1, screen_y1;
    logic signed [31:0] depth_z0, depth_z1;
    logic [1:0] status;

    // model copy of the registers
    longint vp_w = 800, vp_h = 600, bd_w = 800, bd_h = 600;

    screen_line_t pending_lines [$];
    int  errors = 0;
    bit  gaps_on = 1'b1;    // random idling on both sides
    int  quiet_cycles = 0;

    homogeneous_line_clip_viewport DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .start_z(start_z), .start_w(start_w),
        .end_x(end_x), .end_y(end_y), .end_z(end_z), .end_w(end_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_x0(screen_x0), .screen_y0(screen_y0),
        .screen_x1(screen_x1), .screen_y1(screen_y1),
        .depth_z0(depth_z0), .depth_z1(depth_z1), .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------
    function automatic longint unsigned magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sat_32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // quotient rounded half away from zero
    function automatic longint div_near(longint num, longint den);
        longint unsigned a, b, q;
        a = magn(num);
        b = magn(den);
        q = (a + b / 2) / b;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // move p toward q onto one plane; 0 means the endpoint is lost
    function automatic bit clip_to_plane(inout vec4_t p, input vec4_t q,
                                         input int axis, input bit plus);
        longint aw, n, m, d, delta;
        longint unsigned an, ad, tm, r;
        bit tneg;
        aw = (p[3] < 0) ? -p[3] : p[3];
        if (plus)
        begin
            if (!(p[axis] > aw))
                return 1'b1;
            n = p[3] - p[axis];
            m = q[3] - q[axis];
        end
        else
        begin
            if (!(p[axis] < -aw))
                return 1'b1;
            n = p[3] + p[axis];
            m = q[3] + q[axis];
        end
        d = n - m;
        if (d == 0)
            return 1'b0;
        an = magn(n);
        ad = magn(d);
        if (an > ad)
            return 1'b0;
        tm = ((an << hlcv_pkg::T_BITS) + ad / 2) / ad;
        tneg = (n < 0) != (d < 0);
        for (int k = 0; k < 4; k++)
        begin
            delta = q[k] - p[k];
            r = (magn(delta) * tm + (64'd1 << (hlcv_pkg::T_BITS - 1))) >> hlcv_pkg::T_BITS;
            p[k] = sat_32(p[k] + (((delta < 0) != tneg) ? -longint'(r) : longint'(r)));
        end
        return 1'b1;
    endfunction

    function automatic bit clip_point(inout vec4_t p, input vec4_t q);
        for (int i = 0; i < hlcv_pkg::N_PLANES; i++)
            if (!clip_to_plane(p, q, hlcv_pkg::PLANE_AXIS[i], hlcv_pkg::PLANE_PLUS[i]))
                return 1'b0;
        return p[3] != 0;
    endfunction

    function automatic longint clamp_ndc(longint v);
        if (v > hlcv_pkg::NX_LIMIT)
            return hlcv_pkg::NX_LIMIT;
        if (v < -hlcv_pkg::NX_LIMIT)
            return -hlcv_pkg::NX_LIMIT;
        return v;
    endfunction

    // divide and map one endpoint; returns 1 when off screen
    function automatic bit project_point(input vec4_t p, output longint sx,
                                         output longint sy, output longint dz);
        longint one, margin, nx, ny;
        one = 64'sd1 << FRAC;
        margin = (one + 5) / 10;
        nx = clamp_ndc(div_near(p[0] * one, p[3]));
        ny = clamp_ndc(div_near(p[1] * one, p[3]));
        dz = sat_32(div_near(p[2] * one, p[3]));
        sx = sat_32(div_near((nx + one) * vp_w, 2));
        sy = sat_32(div_near((one - ny) * vp_h, 2));
        return sx < -margin || sy < -margin ||
               sx > (bd_w << FRAC) + margin || sy > (bd_h << FRAC) + margin;
    endfunction

    function automatic screen_line_t predict_line(segment_t s);
        vec4_t a, b, ca, cb;
        longint x0, y0, z0, x1, y1, z1;
        bit oka, okb, offa, offb;
        screen_line_t r;
        a = '{longint'(s.sx), longint'(s.sy), longint'(s.sz), longint'(s.sw)};
        b = '{longint'(s.ex), longint'(s.ey), longint'(s.ez), longint'(s.ew)};
        ca = a;
        cb = b;
        r = '{default: '0, st: hlcv_pkg::STATUS_DRAW};
        if (a[3] < 0 && b[3] < 0)
            r.st = hlcv_pkg::STATUS_BEHIND;
        else
        begin
            oka = clip_point(ca, b);
            okb = clip_point(cb, a);
            if (!oka || !okb)
                r.st = hlcv_pkg::STATUS_CLIPPED;
            else
            begin
                offa = project_point(ca, x0, y0, z0);
                offb = project_point(cb, x1, y1, z1);
                r.x0 = x0[31:0]; r.y0 = y0[31:0]; r.z0 = z0[31:0];
                r.x1 = x1[31:0]; r.y1 = y1[31:0]; r.z1 = z1[31:0];
                r.st = (offa || offb) ? hlcv_pkg::STATUS_OFF : hlcv_pkg::STATUS_DRAW;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Checking: one result per accepted output transaction
    // ---------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t %s expected %h actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        screen_line_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lines.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result, expected none actual status %0d",
                         $time, status);
            end
            else
            begin
                e = pending_lines.pop_front();
                check_field("screen_x0", e.x0, screen_x0);
                check_field("screen_y0", e.y0, screen_y0);
                check_field("screen_x1", e.x1, screen_x1);
                check_field("screen_y1", e.y1, screen_y1);
                check_field("depth_z0", e.z0, depth_z0);
                check_field("depth_z1", e.z1, depth_z1);
                check_field("status", 32'(e.st), 32'(status));
            end
        end
    end

    // receiver stalls in random bursts
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("homogeneous_line_clip_viewport: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------------
    task automatic send_segment(segment_t s);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= s.sx; start_y <= s.sy; start_z <= s.sz; start_w <= s.sw;
        end_x <= s.ex; end_y <= s.ey; end_z <= s.ez; end_w <= s.ew;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_lines.push_back(predict_line(s));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_lines.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [hlcv_pkg::IDX_W-1:0] idx,
                             logic [hlcv_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            hlcv_pkg::REG_VIEW_WIDTH:   vp_w = longint'(val);
            hlcv_pkg::REG_VIEW_HEIGHT:  vp_h = longint'(val);
            hlcv_pkg::REG_BOUND_WIDTH:  bd_w = longint'(val);
            default:                    bd_h = longint'(val);
        endcase
    endtask

    task automatic set_viewport(int vw, int vh, int bw, int bh);
        write_reg(hlcv_pkg::REG_VIEW_WIDTH, hlcv_pkg::CFG_W'(vw));
        write_reg(hlcv_pkg::REG_VIEW_HEIGHT, hlcv_pkg::CFG_W'(vh));
        write_reg(hlcv_pkg::REG_BOUND_WIDTH, hlcv_pkg::CFG_W'(bw));
        write_reg(hlcv_pkg::REG_BOUND_HEIGHT, hlcv_pkg::CFG_W'(bh));
    endtask

    function automatic segment_t seg(int sx, int sy, int sz, int sw,
                                     int ex, int ey, int ez, int ew);
        segment_t s;
        s = '{sx, sy, sz, sw, ex, ey, ez, ew};
        return s;
    endfunction

    // well-formed endpoint: w mostly positive, coordinates within +-2w
    function automatic void rand_point(output int x, output int y,
                                       output int z, output int w);
        int unsigned aw;
        aw = $urandom_range(32'h4000, 32'h40000);
        x = int'($urandom_range(0, 4 * aw)) - int'(2 * aw);
        y = int'($urandom_range(0, 4 * aw)) - int'(2 * aw);
        z = int'($urandom_range(0, 4 * aw)) - int'(2 * aw);
        w = ($urandom_range(0, 9) == 0) ? -int'(aw) : int'(aw);
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        int x, y, z, w;
        rand_point(x, y, z, w);
        s.sx = x; s.sy = y; s.sz = z; s.sw = w;
        rand_point(x, y, z, w);
        s.ex = x; s.ey = y; s.ez = z; s.ew = w;
        return s;
    endfunction

    function automatic segment_t noise_segment();
        segment_t s;
        s = '{$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    localparam int ONE = 32'h10000;

    task automatic test_special_cases();
        send_segment(seg(0, 0, 0, ONE, ONE / 2, ONE / 2, 0, ONE));          // inside
        send_segment(seg(0, 0, 0, -ONE, 0, 0, 0, -ONE));                    // behind
        send_segment(seg(2 * ONE, 0, 0, ONE, 0, 0, 0, ONE));                // x+ clip
        send_segment(seg(0, -3 * ONE, 0, ONE, 0, 0, ONE / 2, ONE));         // y- clip
        send_segment(seg(0, 0, 2 * ONE, ONE, 0, 0, -2 * ONE, ONE));         // z both
        send_segment(seg(2 * ONE, 0, 0, ONE, 2 * ONE, 0, 0, ONE));          // zero denom
        send_segment(seg(3 * ONE, 0, 0, ONE, 4 * ONE, 0, 0, 2 * ONE));      // zero denom
        send_segment(seg(ONE, 0, 0, 0, -ONE, 0, 0, 0));                     // w zero
        send_segment(seg(0, 0, 0, ONE, ONE, ONE, 0, ONE + ONE / 4));        // inside
        send_segment(seg(-ONE, -ONE, 0, ONE, ONE, ONE, 0, ONE));            // corners
        send_segment(seg(0, 0, 0, -ONE, ONE / 2, 0, 0, ONE));               // one w negative
        send_segment(seg(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        send_segment(seg(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF));
        send_segment(seg(0, 0, 0, 1, 0, 0, 0, 1));                          // tiny w
        send_segment(seg(-1, -1, -1, -1, -1, -1, -1, -1));
        send_segment(seg(1, 1, 1, 1, 1, 1, 1, 1));
        wait_drained();
    endtask

    task automatic test_viewport_extremes();
        set_viewport(1, 1, 0, 0);
        repeat (20) send_segment(rand_segment());
        wait_drained();
        set_viewport(4096, 4096, 4096, 4096);
        repeat (20) send_segment(rand_segment());
        send_segment(seg(32'h7FFFFFFF, 32'h80000000, 0, 1, 0, 0, 0, ONE));
        wait_drained();
        set_viewport(4096, 1, 0, 4096);
        repeat (15) send_segment(rand_segment());
        wait_drained();
    endtask

    task automatic test_random_segments(int count);
        for (int i = 0; i < count; i++)
            send_segment(($urandom_range(0, 4) == 0) ? noise_segment() : rand_segment());
    endtask

    task automatic test_random_viewports();
        for (int ph = 0; ph < 4; ph++)
        begin
            set_viewport($urandom_range(1, 4096), $urandom_range(1, 4096),
                         $urandom_range(0, 4096), $urandom_range(0, 4096));
            test_random_segments(50);
            // sender holds off until every result is back
            wait_drained();
        end
    endtask

    task automatic test_full_rate();
        set_viewport(800, 600, 800, 600);
        gaps_on = 1'b0;
        test_random_segments(80);
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_random_segments(60);
        wait_drained();
        test_viewport_extremes();
        test_random_viewports();
        test_full_rate();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("homogeneous_line_clip_viewport: match");
        else
            $display("homogeneous_line_clip_viewport: mismatch");
        $finish;
    end
endmodule

### homogeneous_line_clip_viewport.f
design/hlcv_pkg.sv
design/hlcv_div.sv
design/hlcv_plane.sv
design/hlcv_map.sv
design/homogeneous_line_clip_viewport.sv
bench/testbench.sv
